// ===== hw/rtl/voice_volume_mixer_unit_assert.svh =====
// assertion macros shared by the voice volume mixer rtl
`ifndef VOICE_VOLUME_MIXER_UNIT_ASSERT_SVH
`define VOICE_VOLUME_MIXER_UNIT_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define VVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vvm assertion failed");

// next-cycle implication, checked only out of reset
`define VVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vvm assertion failed");

`endif

// ===== hw/rtl/vvm_pkg.sv =====
// shared types, constants and helpers of the voice volume mixer
package vvm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 21;
  localparam int VOL_W      = 8;
  localparam int CH_W       = 2;
  localparam int NUM_SUMS   = 8;
  localparam int AV_W       = 5;

  localparam logic [AV_W-1:0] MIN_LAST_IDX = 5'd7;
  localparam logic [4:0]      SHIFT_BASE   = 5'd20;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [VOL_W-1:0]           volume_t;

  localparam acc_t SAT_MAX = 21'sh007fff;
  localparam acc_t SAT_MIN = -21'sh008000;

  // clamp an accumulator value into 16 signed bits
  function automatic sample_t saturate16(input acc_t v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vvm_scale.sv =====
// exponent/mantissa volume scaling of one sample
module vvm_scale (
  input  vvm_pkg::sample_t sample,
  input  vvm_pkg::volume_t volume,
  output vvm_pkg::sample_t scaled
);
  import vvm_pkg::*;

  logic [3:0]         vol_exp;
  logic [3:0]         vol_mant;
  logic signed [21:0] prod;
  logic signed [21:0] shifted;
  logic [4:0]         shamt;

  // gain factor is 16 + mantissa, shift is 20 - exponent (floor); exponent 0 gives zero
  always_comb begin
    vol_exp  = volume[7:4];
    vol_mant = volume[3:0];
    prod     = 22'(sample) * 22'($signed({2'b01, vol_mant}));
    shamt    = SHIFT_BASE - {1'b0, vol_exp};
    shifted  = prod >>> shamt;
    if (vol_exp == 4'd0) begin
      scaled = '0;
    end else begin
      scaled = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/voice_volume_mixer_unit.sv =====
// voice volume mixer top level: input register, mix logic, result register
//
// Usage: voices arrive on the in_ channel (valid/ready), one item per voice
// in voice order, each with sample, busy flag, left/right volume and channel.
// Busy voices are scaled by their volumes and added into the left/right sums
// of their channel. The item of voice index active_voices (at least 7, at most
// MAX_VOICES-1) closes the frame: all eight sums, saturated to 16 bits, go out
// as one item on the out_ channel and the sums and voice counter clear.
// Throughput: one voice per cycle, sustained while no closing voice waits. A
// frame result is valid from the edge at which its last voice leaves the
// input register. The left and right scaling multiplies and the 21-bit add
// per sum sit between the input and result registers.
// If the result register still holds an untaken frame when the next frame
// closes, the closing voice waits in the input register and in_ready drops
// until out_ready frees the result register.
// The cfg_ channel writes active_voices (always ready); write it only idle.
// Reset: active_voices returns to 31, sums and voice counter clear, both
// channels empty.
module voice_volume_mixer_unit #(
  parameter int MAX_VOICES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [4:0]            cfg_active_voices,
  // voice items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vvm_pkg::sample_t      in_sample,
  input  logic                  in_voice_busy,
  input  vvm_pkg::volume_t      in_left_volume,
  input  vvm_pkg::volume_t      in_right_volume,
  input  logic [1:0]            in_channel,
  // frame results
  output logic                  out_valid,
  input  logic                  out_ready,
  output vvm_pkg::sample_t      out_ch0_left,
  output vvm_pkg::sample_t      out_ch0_right,
  output vvm_pkg::sample_t      out_ch1_left,
  output vvm_pkg::sample_t      out_ch1_right,
  output vvm_pkg::sample_t      out_ch2_left,
  output vvm_pkg::sample_t      out_ch2_right,
  output vvm_pkg::sample_t      out_ch3_left,
  output vvm_pkg::sample_t      out_ch3_right
);
  import vvm_pkg::*;

  localparam int              CNT_W   = $clog2(MAX_VOICES);
  localparam logic [AV_W-1:0] MAX_IDX = AV_W'(MAX_VOICES - 1);

  // configuration register
  logic [AV_W-1:0] active_r;

  // input register
  logic    s1_valid_r;
  sample_t s1_sample_r;
  logic    s1_busy_r;
  volume_t s1_lvol_r;
  volume_t s1_rvol_r;
  logic [CH_W-1:0] s1_ch_r;

  // mix state and result register
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  acc_t    sum_r   [NUM_SUMS];
  acc_t    sum_nxt [NUM_SUMS];
  sample_t out_r   [NUM_SUMS];
  logic    out_valid_r;

  logic [AV_W-1:0] last_idx;
  logic    s1_end;
  logic    s1_fire;
  sample_t scaled_l;
  sample_t scaled_r;

  // configuration write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 5'd31;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_active_voices;
    end
  end

  // last voice index of a frame, clamped both ways
  always_comb begin
    last_idx = active_r;
    if (last_idx < MIN_LAST_IDX) begin
      last_idx = MIN_LAST_IDX;
    end
    if (last_idx > MAX_IDX) begin
      last_idx = MAX_IDX;
    end
  end

  // handshake: a closing voice waits while an untaken frame blocks the output
  assign s1_end   = (AV_W'(cnt_r) >= last_idx);
  assign s1_fire  = s1_valid_r && !(s1_end && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_busy_r   <= in_voice_busy;
      s1_lvol_r   <= in_left_volume;
      s1_rvol_r   <= in_right_volume;
      s1_ch_r     <= in_channel;
    end
  end

  // left and right scaling
  vvm_scale u_scale_l (
    .sample (s1_sample_r),
    .volume (s1_lvol_r),
    .scaled (scaled_l)
  );

  vvm_scale u_scale_r (
    .sample (s1_sample_r),
    .volume (s1_rvol_r),
    .scaled (scaled_r)
  );

  // per-sum accumulate: even slots left, odd slots right
  always_comb begin
    for (int i = 0; i < NUM_SUMS; i++) begin
      sum_nxt[i] = sum_r[i];
      if (s1_busy_r && (s1_ch_r == CH_W'(i / 2))) begin
        if ((i % 2) == 0) begin
          sum_nxt[i] = sum_r[i] + ACC_W'(scaled_l);
        end else begin
          sum_nxt[i] = sum_r[i] + ACC_W'(scaled_r);
        end
      end
    end
  end

  // voice counter
  assign cnt_nxt = s1_end ? '0 : cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < NUM_SUMS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (s1_fire) begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < NUM_SUMS; i++) begin
        sum_r[i] <= s1_end ? '0 : sum_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      for (int i = 0; i < NUM_SUMS; i++) begin
        out_r[i] <= saturate16(sum_nxt[i]);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ch0_left  = out_r[0];
  assign out_ch0_right = out_r[1];
  assign out_ch1_left  = out_r[2];
  assign out_ch1_right = out_r[3];
  assign out_ch2_left  = out_r[4];
  assign out_ch2_right = out_r[5];
  assign out_ch3_left  = out_r[6];
  assign out_ch3_right = out_r[7];

  // checks
`include "voice_volume_mixer_unit_assert.svh"

  `VVM_ASSERT_NEXT(a_frame_end_loads_out, s1_fire && s1_end, out_valid_r)
  `VVM_ASSERT_NEXT(a_frame_end_clears, s1_fire && s1_end, cnt_r == '0 && sum_r[0] == '0)
  `VVM_ASSERT_NOW(a_blocked_frame_stalls,
                  s1_valid_r && s1_end && out_valid_r && !out_ready, !in_ready)

endmodule
